FILE: hw/rtl/cpdd_pkg.sv
// ----------------------------------------------------------------------------
// cpdd_pkg: shared types and constants of the class peak decision detector
// Widths of the probability, tick and action fields, configuration register
// indexes and reset values, the scan token and the cell control bundle.
// ----------------------------------------------------------------------------
package cpdd_pkg;

  localparam int unsigned PROB_W    = 16;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned ZRUN_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_RATIO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REBOUND_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RUN_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [PROB_W-1:0] RST_PEAK_MIN       = 16'd19661;
  localparam logic [PROB_W-1:0] RST_DROP_RATIO     = 16'd58982;
  localparam logic [PROB_W-1:0] RST_REBOUND_RATIO  = 16'd6554;
  localparam logic [PROB_W-1:0] RST_ZERO_LEVEL     = 16'd1;
  localparam logic [ZRUN_W-1:0] RST_ZERO_RUN_LIMIT = 8'd5;

  typedef logic [PROB_W-1:0] prob_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [ACT_W-1:0]  act_t;

  // Scan token: running context handed from one class cell to the next.
  // Class indexes use the action width, which covers up to eight classes.
  typedef struct packed {
    logic  valid;
    act_t  best_idx;
    prob_t best_peak;
    logic  reb;          // rebound still pending
    logic  winner_none;
    act_t  last_winner;
    prob_t wcur;         // this item's value of the last winner class
    logic  all_zero;
    logic  hit;          // a class was declared during this scan
    prob_t hit_peak;
  } scan_tok_t;

  // Values every cell sees; only clear and config writes change them mid-scan.
  typedef struct packed {
    logic           clear;
    prob_t          peak_min;
    prob_t          drop_ratio;
    prob_t          zero_level;
    prob_t          winner_peak;
    logic [31:0]    reb_thresh;   // rebound_ratio * last winner peak
    tick_t          tick;
    logic           decided_once;
    tick_t          decision_tick;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/cpdd_in_if.sv
// ----------------------------------------------------------------------------
// cpdd_in_if: input channel of the class peak decision detector
// One item is a vector of class probabilities, class 0 (prob_a) in the low
// lane, each lane unsigned Q0.16.
// ----------------------------------------------------------------------------
interface cpdd_in_if #(
  parameter int unsigned NUM_CLASSES = 4
);
  logic                                    valid;
  logic                                    ready;
  logic [NUM_CLASSES*cpdd_pkg::PROB_W-1:0] prob;

  modport source (output valid, output prob, input ready);
  modport sink   (input valid, input prob, output ready);
endinterface

FILE: hw/rtl/cpdd_out_if.sv
// ----------------------------------------------------------------------------
// cpdd_out_if: result channel of the class peak decision detector
// One item is the declared action and the peak of the declared class.
// ----------------------------------------------------------------------------
interface cpdd_out_if;
  logic            valid;
  logic            ready;
  cpdd_pkg::act_t  action;
  cpdd_pkg::prob_t decided_peak;

  modport source (output valid, output action, output decided_peak, input ready);
  modport sink   (input valid, input action, input decided_peak, output ready);
endinterface

FILE: hw/rtl/class_peak_decision_detector_core.sv
// ----------------------------------------------------------------------------
// class_peak_decision_detector_core: peak-based class decision detector
// Tracks per-class peaks over a stream of probability vectors and declares a
// class once its peak has passed and fallen off, or none after a zero run.
// ----------------------------------------------------------------------------
// From acceptance to result, an item goes through these steps: the load
// state forms the rebound threshold product and the scan token, the token
// then visits one class cell per cycle in index order, and the wrap-up
// state updates the zero run and writes the result register.
// in_ch.ready is high only between items; a result waiting in the output
// register does not block the next item, but wrap-up holds while a new result
// cannot be placed. At most one result comes out per item. After reset all
// state is ready at once; configuration writes can reach an item in flight.
module class_peak_decision_detector_core #(
  parameter int unsigned NUM_CLASSES = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  cpdd_in_if.sink                               in_ch,
  cpdd_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [cpdd_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [cpdd_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int unsigned IW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam cpdd_pkg::act_t ACT_NONE = cpdd_pkg::act_t'(NUM_CLASSES % 8);
  localparam int unsigned PW = cpdd_pkg::PROB_W;

  typedef enum logic [1:0] {IDLE, LOAD, SCAN, WRAP} state_t;

  // configuration
  cpdd_pkg::prob_t             peak_min_r;
  cpdd_pkg::prob_t             drop_ratio_r;
  cpdd_pkg::prob_t             rebound_ratio_r;
  cpdd_pkg::prob_t             zero_level_r;
  logic [cpdd_pkg::ZRUN_W-1:0] zero_run_limit_r;

  // persistent scan state
  state_t                      state_r;
  cpdd_pkg::prob_t             prob_r [NUM_CLASSES];
  cpdd_pkg::tick_t             tick_count_r;
  cpdd_pkg::act_t              best_index_r;
  logic                        reb_r;
  logic                        winner_none_r;
  cpdd_pkg::act_t              last_winner_r;
  cpdd_pkg::prob_t             lwp_r;
  cpdd_pkg::tick_t             decision_tick_r;
  logic                        decided_once_r;
  logic [cpdd_pkg::ZRUN_W-1:0] zero_run_r;
  logic [31:0]                 reb_thresh_r;
  cpdd_pkg::scan_tok_t         tok0_r;
  cpdd_pkg::scan_tok_t         fin_r;
  logic                        out_valid_r;
  cpdd_pkg::act_t              out_action_r;
  cpdd_pkg::prob_t             out_peak_r;

  cpdd_pkg::scan_tok_t         tok_link [NUM_CLASSES+1];
  cpdd_pkg::prob_t             cell_peak [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]      decl_vec;
  logic [NUM_CLASSES:0]        tok_valid_vec;
  cpdd_pkg::cell_ctl_t         ctl;

  logic                        in_acc;
  logic [cpdd_pkg::ZRUN_W-1:0] zr_inc;
  logic                        none;
  logic                        produce;
  logic                        wrap_go;
  logic                        wrap_clear;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == IDLE);

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_min_r       <= cpdd_pkg::RST_PEAK_MIN;
      drop_ratio_r     <= cpdd_pkg::RST_DROP_RATIO;
      rebound_ratio_r  <= cpdd_pkg::RST_REBOUND_RATIO;
      zero_level_r     <= cpdd_pkg::RST_ZERO_LEVEL;
      zero_run_limit_r <= cpdd_pkg::RST_ZERO_RUN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        cpdd_pkg::CFG_PEAK_MIN:       peak_min_r       <= cfg_wdata;
        cpdd_pkg::CFG_DROP_RATIO:     drop_ratio_r     <= cfg_wdata;
        cpdd_pkg::CFG_REBOUND_RATIO:  rebound_ratio_r  <= cfg_wdata;
        cpdd_pkg::CFG_ZERO_LEVEL:     zero_level_r     <= cfg_wdata;
        cpdd_pkg::CFG_ZERO_RUN_LIMIT: zero_run_limit_r <= cfg_wdata[cpdd_pkg::ZRUN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- input vector hold
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        prob_r[c] <= in_ch.prob[c*PW +: PW];
      end
    end
  end

  // ---- cell row
  assign tok_link[0] = tok0_r;

  always_comb begin
    ctl.clear         = (|decl_vec) || wrap_clear;
    ctl.peak_min      = peak_min_r;
    ctl.drop_ratio    = drop_ratio_r;
    ctl.zero_level    = zero_level_r;
    ctl.winner_peak   = lwp_r;
    ctl.reb_thresh    = reb_thresh_r;
    ctl.tick          = tick_count_r;
    ctl.decided_once  = decided_once_r;
    ctl.decision_tick = decision_tick_r;
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cell
    cpdd_cell #(
      .CLASS_IDX (c)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .prob    (prob_r[c]),
      .ctl     (ctl),
      .tok_in  (tok_link[c]),
      .tok_out (tok_link[c+1]),
      .peak    (cell_peak[c]),
      .decl    (decl_vec[c])
    );
  end

  for (genvar c = 0; c <= NUM_CLASSES; c++) begin : g_tv
    assign tok_valid_vec[c] = tok_link[c].valid;
  end

  // ---- wrap-up
  always_comb begin
    if (!fin_r.all_zero) begin
      zr_inc = '0;
    end else if (zero_run_r == '1) begin
      zr_inc = zero_run_r;
    end else begin
      zr_inc = zero_run_r + 1'b1;
    end
    none       = zr_inc > zero_run_limit_r;
    produce    = none || fin_r.hit;
    wrap_go    = (state_r == WRAP) && (!produce || !out_valid_r || out_ch.ready);
    wrap_clear = wrap_go && none;
  end

  // ---- sequencer, scan state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= IDLE;
      tick_count_r    <= '0;
      best_index_r    <= '0;
      reb_r           <= 1'b1;
      winner_none_r   <= 1'b1;
      last_winner_r   <= '1;
      lwp_r           <= '0;
      decision_tick_r <= '0;
      decided_once_r  <= 1'b0;
      zero_run_r      <= '0;
      tok0_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      tok0_r.valid <= 1'b0;
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_acc) begin
            tick_count_r <= tick_count_r + 1'b1;
            state_r      <= LOAD;
          end
        end
        LOAD: begin
          reb_thresh_r       <= {16'h0, rebound_ratio_r} * {16'h0, lwp_r};
          tok0_r.valid       <= 1'b1;
          tok0_r.best_idx    <= best_index_r;
          tok0_r.best_peak   <= cell_peak[best_index_r[IW-1:0]];
          tok0_r.reb         <= reb_r;
          tok0_r.winner_none <= winner_none_r;
          tok0_r.last_winner <= last_winner_r;
          tok0_r.wcur        <= prob_r[last_winner_r[IW-1:0]];
          tok0_r.all_zero    <= 1'b1;
          tok0_r.hit         <= 1'b0;
          tok0_r.hit_peak    <= '0;
          state_r            <= SCAN;
        end
        SCAN: begin
          if (tok_link[NUM_CLASSES].valid) begin
            fin_r   <= tok_link[NUM_CLASSES];
            state_r <= WRAP;
          end
        end
        WRAP: begin
          if (wrap_go) begin
            if (fin_r.hit) begin
              decided_once_r  <= 1'b1;
              decision_tick_r <= tick_count_r;
            end
            if (none) begin
              zero_run_r    <= '0;
              best_index_r  <= '0;
              reb_r         <= 1'b1;
              winner_none_r <= 1'b1;
              last_winner_r <= '1;
              lwp_r         <= '0;
              out_valid_r   <= 1'b1;
              out_action_r  <= ACT_NONE;
              out_peak_r    <= '0;
            end else begin
              zero_run_r    <= zr_inc;
              best_index_r  <= fin_r.best_idx;
              reb_r         <= fin_r.reb;
              winner_none_r <= fin_r.winner_none;
              last_winner_r <= fin_r.last_winner;
              if (fin_r.hit) begin
                lwp_r        <= fin_r.hit_peak;
                out_valid_r  <= 1'b1;
                out_action_r <= fin_r.last_winner;
                out_peak_r   <= fin_r.hit_peak;
              end
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = out_action_r;
  assign out_ch.decided_peak = out_peak_r;

`ifndef SYNTHESIS
  a_one_decl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(decl_vec))
    else $error("more than one class declared in a cycle");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one scan item in the cell row");

  a_decl_vs_none: assert property (@(posedge clk) disable iff (!rst_n)
    !((|decl_vec) && wrap_clear))
    else $error("class declaration and zero-run clear in the same cycle");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == LOAD))
    else $error("accepted item did not start a load");

  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (wrap_go && fin_r.hit && !none) |=>
      (out_valid_r && (out_action_r == $past(fin_r.last_winner))))
    else $error("declared class not placed in result register");
`endif

endmodule

FILE: hw/rtl/cpdd_cell.sv
// ----------------------------------------------------------------------------
// cpdd_cell: one class cell of the scan chain
// Holds the peak, peak tick and arming flag of one class. When the scan token
// arrives, updates them, moves the best-peak index, tests for a declaration
// and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module cpdd_cell #(
  parameter int unsigned CLASS_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpdd_pkg::prob_t     prob,
  input  cpdd_pkg::cell_ctl_t ctl,
  input  cpdd_pkg::scan_tok_t tok_in,
  output cpdd_pkg::scan_tok_t tok_out,
  output cpdd_pkg::prob_t     peak,
  output logic                decl
);

  localparam cpdd_pkg::act_t MY_IDX = cpdd_pkg::act_t'(CLASS_IDX);

  cpdd_pkg::prob_t     peak_r;
  cpdd_pkg::tick_t     peak_tick_r;
  logic                armed_clear_r;
  cpdd_pkg::scan_tok_t tok_r;

  cpdd_pkg::scan_tok_t tok_nxt;
  cpdd_pkg::prob_t     peak_nxt;
  cpdd_pkg::tick_t     peak_tick_nxt;
  logic                armed_clear_nxt;

  logic        present;
  logic        is_win;
  logic        reb_hit;
  logic        reb_nxt;
  logic        grow;
  logic        upd;
  logic [31:0] drop_prod;
  logic        after_last;
  logic        gate;

  // The drop test uses the stored peak: when the peak grows on this item the
  // value equals the new peak and the test fails either way.
  assign drop_prod = {16'h0, ctl.drop_ratio} * {16'h0, peak_r};

  always_comb begin
    present = prob >= ctl.zero_level;
    is_win  = !tok_in.winner_none && (tok_in.last_winner == MY_IDX);
    reb_hit = is_win && present && tok_in.reb &&
              ((prob >= ctl.winner_peak) || ({prob, 16'h0} <= ctl.reb_thresh));
    reb_nxt = tok_in.reb && !reb_hit;
    grow    = prob > peak_r;
    upd     = grow && (!is_win || !reb_nxt);

    peak_nxt        = upd ? prob : peak_r;
    peak_tick_nxt   = upd ? ctl.tick : peak_tick_r;
    armed_clear_nxt = armed_clear_r &&
                      !(grow && !is_win && (tok_in.winner_none || prob > tok_in.wcur));

    tok_nxt = tok_in;
    decl    = 1'b0;
    if (tok_in.valid) begin
      tok_nxt.reb      = reb_nxt;
      tok_nxt.all_zero = tok_in.all_zero && !present;
      if (tok_in.best_idx == MY_IDX) begin
        tok_nxt.best_peak = peak_nxt;
      end else if (peak_nxt > tok_in.best_peak) begin
        tok_nxt.best_idx  = MY_IDX;
        tok_nxt.best_peak = peak_nxt;
      end

      after_last = !ctl.decided_once ||
                   ({1'b0, peak_tick_nxt} > ({1'b0, ctl.decision_tick} + 33'd1));
      gate = is_win ? ({peak_nxt, 16'h0} > ctl.reb_thresh) : !armed_clear_nxt;
      decl = (peak_nxt > ctl.peak_min) && ({prob, 16'h0} < drop_prod) &&
             after_last && present && (tok_nxt.best_idx == MY_IDX) && gate;

      // declare: record the winner, restart the running best
      if (decl) begin
        tok_nxt.hit         = 1'b1;
        tok_nxt.hit_peak    = peak_nxt;
        tok_nxt.winner_none = 1'b0;
        tok_nxt.last_winner = MY_IDX;
        tok_nxt.wcur        = prob;
        tok_nxt.best_idx    = '0;
        tok_nxt.best_peak   = '0;
        tok_nxt.reb         = 1'b1;
      end
    end else begin
      after_last = 1'b0;
      gate       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r        <= '0;
      peak_tick_r   <= '0;
      armed_clear_r <= 1'b1;
      tok_r         <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (ctl.clear) begin
        peak_r        <= '0;
        peak_tick_r   <= '0;
        armed_clear_r <= 1'b1;
      end else if (tok_in.valid) begin
        peak_r        <= peak_nxt;
        peak_tick_r   <= peak_tick_nxt;
        armed_clear_r <= armed_clear_nxt;
      end
    end
  end

  assign tok_out = tok_r;
  assign peak    = peak_r;

endmodule
